// ----- design/binary_max_heap_queue_macros.svh -----
// Assertion macros for the binary max-heap queue.
// Used by the controller and datapath; needs signals clk and rst_n in scope.
`ifndef BINARY_MAX_HEAP_QUEUE_MACROS_SVH
`define BINARY_MAX_HEAP_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
`define BMHQ_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define BMHQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BMHQ_ASSERT(label, expr, msg)
`define BMHQ_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- design/bmhq_pkg.sv -----
// Shared types and constants for the binary max-heap queue.
// No dependencies; used by bmhq_dp, bmhq_ctrl and the top level.
`timescale 1ns / 1ps
package bmhq_pkg;

    localparam int OP_W      = 2;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 9;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT  = 2'd0,
        OP_EXTRACT = 2'd1,
        OP_PEEK    = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic    load_in;
        logic    up_init;
        logic    up_read;
        logic    up_step;
        logic    ex_read;
        logic    ex_take;
        logic    pk_read;
        logic    pk_take;
        logic    down_read;
        logic    down_step;
        logic    write_hold;
        logic    set_status;
        status_t status;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic full;
        logic empty;
        logic last_one;
        logic pos_zero;
        logic l_in;
        logic up_gt;
        logic down_move;
    } dp_stat_t;

endpackage

// ----- design/binary_max_heap_queue.sv -----
// Binary max-heap priority queue of signed 32-bit values: insert, extract maximum, peek.
// One operation per input transfer, one result per operation. Each operation runs to
// completion before the next is taken. An error or the unused op code goes from decode
// straight to the finish state, and a peek reads the root once. Insert and extract sift
// through the tree: per tree level there is one state that reads the heap memory and one
// that compares and writes back. A finished result waits in an output register, so the
// next operation is accepted while it is still pending. The operation after that holds in
// its finish state until the pending result is taken. Depends on bmhq_pkg, bmhq_ctrl and
// bmhq_dp.
`timescale 1ns / 1ps
module binary_max_heap_queue #(
    parameter int CAPACITY = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [bmhq_pkg::S_TDATA_W-1:0]     s_tdata,  // op[1:0], value[33:2], zero pad
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bmhq_pkg::M_TDATA_W-1:0]     m_tdata   // result_value[31:0], status[33:32],
                                                         // count[42:34], zero pad
);
    import bmhq_pkg::*;

    dp_cmd_t                   cmd;
    dp_stat_t                  stat;
    logic signed [VALUE_W-1:0] result_value;
    status_t                   status;
    logic [COUNT_W-1:0]        count;

    bmhq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    bmhq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_op      (s_tdata[OP_W-1:0]),
        .in_value   (s_tdata[OP_W+VALUE_W-1:OP_W]),
        .out_value  (result_value),
        .out_status (status),
        .out_count  (count)
    );

    assign m_tdata = {{(M_TDATA_W - VALUE_W - STATUS_W - COUNT_W){1'b0}},
                      count, status, result_value};

endmodule

// ----- design/bmhq_dp.sv -----
// Datapath of the binary max-heap queue: heap memory, sift registers, result registers.
// Depends on bmhq_pkg and binary_max_heap_queue_macros.svh.
`timescale 1ns / 1ps
`include "binary_max_heap_queue_macros.svh"
module bmhq_dp #(
    parameter int CAPACITY = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bmhq_pkg::dp_cmd_t                   cmd,
    output bmhq_pkg::dp_stat_t                  stat,
    input  logic [bmhq_pkg::OP_W-1:0]           in_op,
    input  logic signed [bmhq_pkg::VALUE_W-1:0] in_value,
    output logic signed [bmhq_pkg::VALUE_W-1:0] out_value,
    output bmhq_pkg::status_t                   out_status,
    output logic [bmhq_pkg::COUNT_W-1:0]        out_count
);
    import bmhq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [VALUE_W-1:0]        mem [CAPACITY];
    logic [AW-1:0]             raddr0;
    logic [AW-1:0]             raddr1;
    logic                      mem_we;
    logic [AW-1:0]             waddr;
    logic [VALUE_W-1:0]        wdata;
    logic signed [VALUE_W-1:0] rd0_reg;
    logic signed [VALUE_W-1:0] rd1_reg;

    op_t                       op_reg;
    logic signed [VALUE_W-1:0] val_reg;
    logic signed [VALUE_W-1:0] hold_reg;
    logic [AW-1:0]             pos_reg;
    logic [CW-1:0]             count_reg;
    logic signed [VALUE_W-1:0] res_value_reg;
    status_t                   res_status_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    status_t                   out_status_reg;
    logic [CW-1:0]             out_count_reg;

    logic [AW:0]               l_idx;
    logic [AW+1:0]             r_idx;
    logic [AW-1:0]             parent;
    logic                      r_in;
    logic                      l_gt;
    logic                      r_gt;
    logic signed [VALUE_W-1:0] l_win;

    assign l_idx  = {pos_reg, 1'b1};
    assign r_idx  = {1'b0, l_idx} + (AW + 2)'(1);
    assign parent = AW'((pos_reg - AW'(1)) >> 1);
    assign r_in   = r_idx < (AW + 2)'(count_reg);
    assign l_gt   = rd0_reg > hold_reg;
    assign l_win  = l_gt ? rd0_reg : hold_reg;
    assign r_gt   = r_in && (rd1_reg > l_win);

    always_comb
    begin
        stat.op        = op_reg;
        stat.full      = count_reg >= CW'(CAPACITY);
        stat.empty     = count_reg == '0;
        stat.last_one  = count_reg == CW'(1);
        stat.pos_zero  = pos_reg == '0;
        stat.l_in      = (AW + 1)'(count_reg) > l_idx;
        stat.up_gt     = hold_reg > rd0_reg;
        stat.down_move = l_gt || r_gt;
    end

    always_comb
    begin
        raddr0 = '0;
        raddr1 = '0;
        if (cmd.ex_read)
        begin
            raddr1 = AW'(count_reg - CW'(1));
        end
        if (cmd.up_read)
        begin
            raddr0 = parent;
        end
        if (cmd.down_read)
        begin
            raddr0 = AW'(l_idx);
            raddr1 = AW'(r_idx);
        end
    end

    always_comb
    begin
        mem_we = 1'b0;
        waddr  = pos_reg;
        wdata  = hold_reg;
        if (cmd.write_hold)
        begin
            mem_we = 1'b1;
        end
        if (cmd.up_step)
        begin
            mem_we = 1'b1;
            if (stat.up_gt)
            begin
                wdata = rd0_reg;
            end
        end
        if (cmd.down_step)
        begin
            mem_we = 1'b1;
            if (r_gt)
            begin
                wdata = rd1_reg;
            end
            else if (l_gt)
            begin
                wdata = rd0_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        rd0_reg <= mem[raddr0];
        rd1_reg <= mem[raddr1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.up_init)
        begin
            count_reg <= count_reg + CW'(1);
        end
        else if (cmd.ex_take)
        begin
            count_reg <= count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg         <= op_t'(in_op);
            val_reg        <= in_value;
            res_value_reg  <= '0;
            res_status_reg <= STATUS_OK;
        end
        if (cmd.set_status)
        begin
            res_status_reg <= cmd.status;
        end
        if (cmd.up_init)
        begin
            pos_reg  <= AW'(count_reg);
            hold_reg <= val_reg;
        end
        if (cmd.up_step && stat.up_gt)
        begin
            pos_reg <= parent;
        end
        if (cmd.ex_take)
        begin
            res_value_reg <= rd0_reg;
            hold_reg      <= rd1_reg;
            pos_reg       <= '0;
        end
        if (cmd.pk_take)
        begin
            res_value_reg <= rd0_reg;
        end
        if (cmd.down_step)
        begin
            if (r_gt)
            begin
                pos_reg <= AW'(r_idx);
            end
            else if (l_gt)
            begin
                pos_reg <= AW'(l_idx);
            end
        end
        if (cmd.out_load)
        begin
            out_value_reg  <= res_value_reg;
            out_status_reg <= res_status_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;
    assign out_count  = COUNT_W'(out_count_reg);

    `BMHQ_ASSERT(dp_count_range, count_reg <= CW'(CAPACITY), "element count above capacity")
    `BMHQ_ASSERT_NEXT(dp_full_no_grow, stat.full, !(count_reg > $past(count_reg)), "count grew while full")
    `BMHQ_ASSERT(dp_sift_bounds, !(cmd.down_read || cmd.up_step || cmd.down_step) || !stat.empty, "sift on empty heap")

endmodule

// ----- design/bmhq_ctrl.sv -----
// Controller state machine of the binary max-heap queue.
// Depends on bmhq_pkg and binary_max_heap_queue_macros.svh; drives bmhq_dp.
`timescale 1ns / 1ps
`include "binary_max_heap_queue_macros.svh"
module bmhq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output bmhq_pkg::dp_cmd_t  cmd,
    input  bmhq_pkg::dp_stat_t stat
);
    import bmhq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_UP_CHK,
        S_UP_CMP,
        S_EX_RD,
        S_PK_RD,
        S_DN_RD,
        S_DN_CMP,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_FINISH;
                case (stat.op)
                    OP_INSERT:
                    begin
                        if (stat.full)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = STATUS_FULL;
                        end
                        else
                        begin
                            cmd.up_init = 1'b1;
                            state_next  = S_UP_CHK;
                        end
                    end
                    OP_EXTRACT:
                    begin
                        if (stat.empty)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = STATUS_EMPTY;
                        end
                        else
                        begin
                            cmd.ex_read = 1'b1;
                            state_next  = S_EX_RD;
                        end
                    end
                    OP_PEEK:
                    begin
                        if (stat.empty)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = STATUS_EMPTY;
                        end
                        else
                        begin
                            cmd.pk_read = 1'b1;
                            state_next  = S_PK_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_UP_CHK:
            begin
                if (stat.pos_zero)
                begin
                    cmd.write_hold = 1'b1;
                    state_next     = S_FINISH;
                end
                else
                begin
                    cmd.up_read = 1'b1;
                    state_next  = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                cmd.up_step = 1'b1;
                state_next  = stat.up_gt ? S_UP_CHK : S_FINISH;
            end
            S_EX_RD:
            begin
                cmd.ex_take = 1'b1;
                state_next  = stat.last_one ? S_FINISH : S_DN_RD;
            end
            S_PK_RD:
            begin
                cmd.pk_take = 1'b1;
                state_next  = S_FINISH;
            end
            S_DN_RD:
            begin
                if (stat.l_in)
                begin
                    cmd.down_read = 1'b1;
                    state_next    = S_DN_CMP;
                end
                else
                begin
                    cmd.write_hold = 1'b1;
                    state_next     = S_FINISH;
                end
            end
            S_DN_CMP:
            begin
                cmd.down_step = 1'b1;
                state_next    = stat.down_move ? S_DN_RD : S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `BMHQ_ASSERT_NEXT(ctrl_out_load_valid, cmd.out_load, m_tvalid, "result not presented after load")
    `BMHQ_ASSERT(ctrl_no_overwrite, !cmd.out_load || !out_valid_reg || m_tready, "pending result overwritten")
    `BMHQ_ASSERT(ctrl_one_step, $onehot0({cmd.up_init, cmd.up_step, cmd.down_step, cmd.ex_take, cmd.pk_take, cmd.write_hold}), "conflicting datapath steps")
    `BMHQ_ASSERT_NEXT(ctrl_accept_decode, s_tvalid && s_tready, state_reg == S_DECODE, "accepted transfer not decoded")

endmodule

// ----- tb/tb_binary_max_heap_queue.sv -----
// Self-checking testbench for binary_max_heap_queue: insert, extract and peek streams
// are checked against a behavioral heap kept in the bench. Depends on bmhq_pkg.
`timescale 1ns / 1ps
module tb_binary_max_heap_queue;
    import bmhq_pkg::*;

    localparam int              HEAP_DEPTH = 256;
    localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

    typedef struct {
        logic [VALUE_W-1:0] value;
        status_t            status;
        logic [COUNT_W-1:0] count;
    } heap_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // op[1:0], value[33:2], zero pad
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // result_value[31:0], status[33:32], count[42:34], pad

    logic signed [VALUE_W-1:0] heap_mirror [HEAP_DEPTH];
    int                        mirror_count;
    heap_result_t              expected_results [$];
    int                        errors;
    int                        hold_left;
    bit                        no_idle;

    binary_max_heap_queue #(
        .CAPACITY(HEAP_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic void swap_mirror(int a, int b);
        logic signed [VALUE_W-1:0] t;
        t = heap_mirror[a];
        heap_mirror[a] = heap_mirror[b];
        heap_mirror[b] = t;
    endfunction

    // Applies one operation to the mirror heap and returns the result it should produce.
    function automatic heap_result_t heap_apply(logic [OP_W-1:0] op, logic [VALUE_W-1:0] val);
        heap_result_t r;
        int pos;
        int par;
        int lc;
        int rc;
        int big;
        r.value  = '0;
        r.status = STATUS_OK;
        case (op)
            OP_INSERT:
            begin
                if (mirror_count >= HEAP_DEPTH)
                    r.status = STATUS_FULL;
                else
                begin
                    heap_mirror[mirror_count] = val;
                    pos = mirror_count;
                    mirror_count++;
                    while (pos > 0)
                    begin
                        par = (pos - 1) / 2;
                        if (!(heap_mirror[pos] > heap_mirror[par]))
                            break;
                        swap_mirror(pos, par);
                        pos = par;
                    end
                end
            end
            OP_EXTRACT:
            begin
                if (mirror_count == 0)
                    r.status = STATUS_EMPTY;
                else
                begin
                    r.value = heap_mirror[0];
                    mirror_count--;
                    heap_mirror[0] = heap_mirror[mirror_count];
                    pos = 0;
                    forever
                    begin
                        lc  = 2 * pos + 1;
                        rc  = lc + 1;
                        big = pos;
                        if (lc >= mirror_count)
                            break;
                        if (heap_mirror[lc] > heap_mirror[big])
                            big = lc;
                        if (rc < mirror_count && heap_mirror[rc] > heap_mirror[big])
                            big = rc;
                        if (big == pos)
                            break;
                        swap_mirror(pos, big);
                        pos = big;
                    end
                end
            end
            OP_PEEK:
            begin
                if (mirror_count == 0)
                    r.status = STATUS_EMPTY;
                else
                    r.value = heap_mirror[0];
            end
            default: ;
        endcase
        r.count = mirror_count[COUNT_W-1:0];
        return r;
    endfunction

    function automatic logic [VALUE_W-1:0] rand_value();
        case ($urandom_range(3))
            0: return $urandom_range(15) - 8;   // narrow range, many equal keys
            1:
            begin
                case ($urandom_range(3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [OP_W-1:0] rand_op();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return OP_INSERT;
        else if (r < 85)
            return OP_EXTRACT;
        else if (r < 95)
            return OP_PEEK;
        return OP_UNUSED;
    endfunction

    task automatic push_op(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] val);
        @(negedge clk);
        while (!no_idle && $urandom_range(99) < 34)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - VALUE_W - OP_W){1'b0}}, val, op};
        do
            @(posedge clk);
        while (!s_tready);
        expected_results.push_back(heap_apply(op, val));
    endtask

    // Receiver side: random stalls, or a long counted hold when one is requested.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else
            m_tready <= no_idle || ($urandom_range(99) >= 34);
    end

    always @(posedge clk)
    begin
        heap_result_t exp_r;
        logic [VALUE_W-1:0]  got_value;
        logic [STATUS_W-1:0] got_status;
        logic [COUNT_W-1:0]  got_count;
        got_value  = m_tdata[VALUE_W-1:0];
        got_status = m_tdata[VALUE_W +: STATUS_W];
        got_count  = m_tdata[VALUE_W + STATUS_W +: COUNT_W];
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected transfer value %0d status %0d count %0d",
                         $time, $signed(got_value), got_status, got_count);
                errors++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (got_value !== exp_r.value)
                begin
                    $display("%0t: result_value expected %0d actual %0d",
                             $time, $signed(exp_r.value), $signed(got_value));
                    errors++;
                end
                if (got_status !== exp_r.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_r.status, got_status);
                    errors++;
                end
                if (got_count !== exp_r.count)
                begin
                    $display("%0t: count expected %0d actual %0d",
                             $time, exp_r.count, got_count);
                    errors++;
                end
            end
        end
    end

    task automatic test_empty_heap();
        push_op(OP_PEEK, 32'h0000_0001);
        push_op(OP_EXTRACT, 32'hffff_ffff);
        push_op(OP_UNUSED, 32'hdead_beef);
    endtask

    task automatic test_directed_values();
        push_op(OP_INSERT, 32'h7fff_ffff);
        push_op(OP_INSERT, 32'h8000_0000);
        push_op(OP_INSERT, 32'h0000_0000);
        push_op(OP_INSERT, 32'hffff_ffff);
        push_op(OP_INSERT, 32'd5);
        push_op(OP_INSERT, 32'd5);
        push_op(OP_INSERT, 32'h8000_0000);
        push_op(OP_PEEK, 32'h5555_5555);
        push_op(OP_UNUSED, 32'h7fff_ffff);
        repeat (7)
            push_op(OP_EXTRACT, 32'haaaa_aaaa);
        push_op(OP_EXTRACT, 32'h0000_0000);
    endtask

    task automatic test_random_mix(input int n);
        repeat (n)
            push_op(rand_op(), rand_value());
    endtask

    task automatic test_backpressure();
        hold_left = 300;
        repeat (25)
            push_op($urandom_range(99) < 70 ? OP_INSERT : OP_PEEK, rand_value());
    endtask

    task automatic test_full_rate();
        no_idle = 1'b1;
        test_random_mix(60);
        no_idle = 1'b0;
    endtask

    task automatic test_fill_and_drain();
        while (mirror_count < HEAP_DEPTH)
            push_op(OP_INSERT, rand_value());
        push_op(OP_INSERT, 32'h7fff_ffff);
        push_op(OP_INSERT, 32'h8000_0000);
        push_op(OP_PEEK, 32'h0);
        while (mirror_count > 0)
            push_op(OP_EXTRACT, rand_value());
        push_op(OP_EXTRACT, 32'h0);
        push_op(OP_PEEK, 32'h0);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        mirror_count = 0;
        errors       = 0;
        hold_left    = 0;
        no_idle      = 1'b0;
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_heap();
        test_directed_values();
        test_random_mix(40);
        test_backpressure();
        test_full_rate();
        test_fill_and_drain();
        test_random_mix(30);

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (50)
            @(posedge clk);
        if (errors == 0)
            $display("tb_binary_max_heap_queue OK");
        else
            $display("tb_binary_max_heap_queue NOT OK");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("%0t: timeout, %0d results outstanding", $time, expected_results.size());
        $display("tb_binary_max_heap_queue NOT OK");
        $finish;
    end

endmodule
